>>> design/fcs_pkg.sv
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared constants and types for the filled circle stamp block.
// ----------------------------------------------------------------------------
package fcs_pkg;

  // Canvas size in pixels
  localparam int CANVAS_WIDTH  = 256;
  localparam int CANVAS_HEIGHT = 256;
  localparam int PIXELS        = CANVAS_WIDTH * CANVAS_HEIGHT;

  // Pixel store geometry
  localparam int ADDR_W  = $clog2(PIXELS);
  localparam int PIXEL_W = 24;
  localparam logic [PIXEL_W-1:0] WHITE_PIXEL = 24'hFFFFFF;

  // Coordinate widths: input fields and clamped box ends (0..size)
  localparam int COORD_W = 12;
  localparam int XB_W    = $clog2(CANVAS_WIDTH + 1);
  localparam int YB_W    = $clog2(CANVAS_HEIGHT + 1);
  localparam int XI_W    = $clog2(CANVAS_WIDTH);
  localparam int YI_W    = $clog2(CANVAS_HEIGHT);

  // Signed pixel offset from center, and its square
  localparam int BMAX_W = (XB_W > YB_W) ? XB_W : YB_W;
  localparam int DX_W   = ((BMAX_W > COORD_W) ? BMAX_W : COORD_W) + 2;
  localparam int SQ_W   = 2 * DX_W;

  // Effective radius: (10 bit * 12 bit) >> 8
  localparam int RAD_W   = 10;
  localparam int SCALE_W = 12;
  localparam int PROD_W  = RAD_W + SCALE_W;
  localparam int R_W     = PROD_W - 8;
  localparam int R2_W    = 2 * R_W;
  localparam int CMP_W   = ((SQ_W + 1) > R2_W) ? (SQ_W + 1) : R2_W;

  // Width of box bound arithmetic (center +/- radius)
  localparam int BND_W = ((R_W > COORD_W) ? R_W : COORD_W) + 2;

  // Opcodes
  localparam logic OP_STAMP = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Pixel write request into the store
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
  } wr_req_t;

  // Raster engine status
  typedef struct packed {
    logic busy;
  } rast_stat_t;

endpackage

>>> design/filled_circle_stamp_top.sv
// ----------------------------------------------------------------------------
// filled_circle_stamp_top
// Filled circle stamp into a stored 24-bit RGB canvas, with pixel readback.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_ready): one item is a stamp (opcode 0) or a
// pixel read (opcode 1). Output channel (out_valid / out_ready): exactly one
// result item per input item, in order. A stamp result has stamp_done set and
// zero color; a read result carries the stored pixel, or outside_canvas set
// and zero color when the coordinate lies off the canvas.
// Items are processed one at a time. A read is accepted, reads the store
// and then loads its result. A stamp scales the radius, clamps the bounding
// box and walks it one pixel per cycle through the raster engine over the
// single store write port, then loads its result; an empty box is not walked.
// A new item is accepted while a result waits in the output register; its
// result is held back until that register is free.
// Reset starts a clearing pass that writes white to every pixel, one per
// cycle; in_ready stays low during the pass. A stalled receiver holds the
// output register and, once the next item is finished, stalls the input side.
// ----------------------------------------------------------------------------
module filled_circle_stamp_top import fcs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      opcode,
  input  logic signed [COORD_W-1:0] x_pos,
  input  logic signed [COORD_W-1:0] y_pos,
  input  logic [RAD_W-1:0]          radius,
  input  logic [SCALE_W-1:0]        radius_scale,
  input  logic [7:0]                red,
  input  logic [7:0]                green,
  input  logic [7:0]                blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                read_red,
  output logic [7:0]                read_green,
  output logic [7:0]                read_blue,
  output logic                      outside_canvas,
  output logic                      stamp_done
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_STAMP  = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  localparam logic signed [COORD_W:0] X_END = (COORD_W + 1)'(CANVAS_WIDTH);
  localparam logic signed [COORD_W:0] Y_END = (COORD_W + 1)'(CANVAS_HEIGHT);

  logic [2:0]         state;
  logic [ADDR_W-1:0]  clr_cnt;
  logic               is_read_q;
  logic               outside_q;
  logic [ADDR_W-1:0]  rd_addr_q;
  logic [PIXEL_W-1:0] color_q;
  logic [PIXEL_W-1:0] rdata;
  logic               in_acc;
  logic               off_canvas;
  logic               out_free;

  wr_req_t            rast_wr;
  rast_stat_t         rast_st;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [PIXEL_W-1:0] ram_wdata;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // read coordinate range check
  assign off_canvas = (x_pos < 0) || ({x_pos[COORD_W-1], x_pos} >= X_END) ||
                      (y_pos < 0) || ({y_pos[COORD_W-1], y_pos} >= Y_END);

  // raster engine
  fcs_raster u_raster (
    .clk          (clk),
    .rst          (rst),
    .start        (in_acc && (opcode == OP_STAMP)),
    .cx           (x_pos),
    .cy           (y_pos),
    .radius       (radius),
    .radius_scale (radius_scale),
    .wr           (rast_wr),
    .stat         (rast_st)
  );

  // store write mux: clearing pass or raster
  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = WHITE_PIXEL;
    end else begin
      ram_we    = rast_wr.valid;
      ram_waddr = rast_wr.addr;
      ram_wdata = color_q;
    end
  end

  fcs_ram #(
    .DATA_W (PIXEL_W),
    .DEPTH  (PIXELS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state == S_READ),
    .raddr (rd_addr_q),
    .rdata (rdata)
  );

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == ADDR_W'(PIXELS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state <= (opcode == OP_READ) ? S_READ : S_STAMP;
          end
        end
        S_STAMP: begin
          if (!rast_st.busy) begin
            state <= S_FINISH;
          end
        end
        S_READ: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      is_read_q <= (opcode == OP_READ);
      outside_q <= off_canvas;
      color_q   <= {red, green, blue};
      rd_addr_q <= ADDR_W'(y_pos[YI_W-1:0]) * ADDR_W'(CANVAS_WIDTH) +
                   ADDR_W'(x_pos[XI_W-1:0]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      stamp_done     <= !is_read_q;
      outside_canvas <= is_read_q && outside_q;
      if (is_read_q && !outside_q) begin
        read_red   <= rdata[23:16];
        read_green <= rdata[15:8];
        read_blue  <= rdata[7:0];
      end else begin
        read_red   <= '0;
        read_green <= '0;
        read_blue  <= '0;
      end
    end
  end

  // raster never writes during the clearing pass
  a_no_rast_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !rast_wr.valid)
    else $error("raster write during clearing pass");

  // raster only runs while a stamp is in progress
  a_rast_in_stamp: assert property (@(posedge clk) disable iff (rst)
    rast_st.busy |-> (state == S_STAMP))
    else $error("raster busy outside stamp");

  // a finished stamp goes straight to result loading
  a_stamp_to_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_STAMP && !rast_st.busy) |=> (state == S_FINISH))
    else $error("stamp did not finish");

  // a result waits while the output register is occupied
  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_valid && !out_ready) |=> (state == S_FINISH && out_valid))
    else $error("result loaded over a pending one");

endmodule

>>> design/fcs_ram.sv
// ----------------------------------------------------------------------------
// fcs_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module fcs_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/fcs_raster.sv
// ----------------------------------------------------------------------------
// fcs_raster
// Circle raster engine: scales the radius, clamps the bounding box and walks
// it one pixel per cycle, issuing a store write for every box pixel in the disc.
// ----------------------------------------------------------------------------
module fcs_raster import fcs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [COORD_W-1:0] cx,
  input  logic signed [COORD_W-1:0] cy,
  input  logic [RAD_W-1:0]          radius,
  input  logic [SCALE_W-1:0]        radius_scale,
  output wr_req_t                   wr,
  output rast_stat_t                stat
);

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_MUL  = 2'd1;
  localparam logic [1:0] R_BOX  = 2'd2;
  localparam logic [1:0] R_WALK = 2'd3;

  localparam logic signed [BND_W-1:0] X_LIM = BND_W'(CANVAS_WIDTH);
  localparam logic signed [BND_W-1:0] Y_LIM = BND_W'(CANVAS_HEIGHT);

  logic [1:0] state;

  logic signed [COORD_W-1:0] cx_q, cy_q;
  logic [R_W-1:0]            r_q;
  logic [R2_W-1:0]           r2_q;
  logic [XB_W-1:0]           x0_q, x1_q, x_q;
  logic [YB_W-1:0]           y0_q, y1_q, y_q;

  logic [PROD_W-1:0]         prod;
  logic signed [BND_W-1:0]   r_s, x_lo, x_hi, y_lo, y_hi;
  logic signed [DX_W-1:0]    dx, dy;
  logic signed [SQ_W-1:0]    dx_sq, dy_sq;

  // walk pipeline stage
  logic              p1_v;
  logic [SQ_W-1:0]   p1_dx2, p1_dy2;
  logic [ADDR_W-1:0] p1_addr;
  logic [CMP_W-1:0]  dist2;

  // clamp a bound to 0..lim
  function automatic logic [BND_W-1:0] clamp_bnd(input logic signed [BND_W-1:0] v,
                                                 input logic signed [BND_W-1:0] lim);
    logic [BND_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > lim) begin
      res = lim;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // radius scaling and box bounds
  assign prod = PROD_W'(radius) * PROD_W'(radius_scale);
  assign r_s  = BND_W'(signed'({1'b0, r_q}));
  assign x_lo = BND_W'(cx_q) - r_s;
  assign x_hi = BND_W'(cx_q) + r_s;
  assign y_lo = BND_W'(cy_q) - r_s;
  assign y_hi = BND_W'(cy_q) + r_s;

  // offsets from the center
  assign dx    = DX_W'(signed'({1'b0, x_q})) - DX_W'(cx_q);
  assign dy    = DX_W'(signed'({1'b0, y_q})) - DX_W'(cy_q);
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      p1_v  <= 1'b0;
    end else begin
      p1_v <= 1'b0;
      unique case (state)
        R_IDLE: begin
          if (start) begin
            cx_q  <= cx;
            cy_q  <= cy;
            r_q   <= prod[PROD_W-1:8];
            state <= R_MUL;
          end
        end
        R_MUL: begin
          r2_q  <= R2_W'(r_q) * R2_W'(r_q);
          x0_q  <= XB_W'(clamp_bnd(x_lo, X_LIM));
          x1_q  <= XB_W'(clamp_bnd(x_hi, X_LIM));
          y0_q  <= YB_W'(clamp_bnd(y_lo, Y_LIM));
          y1_q  <= YB_W'(clamp_bnd(y_hi, Y_LIM));
          state <= R_BOX;
        end
        R_BOX: begin
          // empty box: nothing to paint
          if (x0_q >= x1_q || y0_q >= y1_q) begin
            state <= R_IDLE;
          end else begin
            x_q   <= x0_q;
            y_q   <= y0_q;
            state <= R_WALK;
          end
        end
        R_WALK: begin
          p1_v    <= 1'b1;
          p1_dx2  <= $unsigned(dx_sq);
          p1_dy2  <= $unsigned(dy_sq);
          p1_addr <= ADDR_W'(y_q) * ADDR_W'(CANVAS_WIDTH) + ADDR_W'(x_q);
          if (x_q == x1_q - XB_W'(1)) begin
            x_q <= x0_q;
            if (y_q == y1_q - YB_W'(1)) begin
              state <= R_IDLE;
            end else begin
              y_q <= y_q + YB_W'(1);
            end
          end else begin
            x_q <= x_q + XB_W'(1);
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

  // disc test on the registered squares
  assign dist2     = CMP_W'(p1_dx2) + CMP_W'(p1_dy2);
  assign wr.valid  = p1_v && (dist2 <= CMP_W'(r2_q));
  assign wr.addr   = p1_addr;
  assign stat.busy = (state != R_IDLE) || p1_v;

endmodule
